FILE: rtl/core/piaf_pkg.sv
// Shared types and constants for the player input admission filter.
package piaf_pkg;

   // Table sizes
   localparam int PLAYERS      = 4;
   localparam int PARTICIPANTS = 256;
   localparam int OWNER_REGS   = 4;

   // Derived index widths
   localparam int PS_W   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
   localparam int OWN_W  = (OWNER_REGS > 1) ? $clog2(OWNER_REGS) : 1;
   localparam int PART_W = $clog2(PARTICIPANTS);

   // Field widths
   localparam int ID_W    = 8;
   localparam int SLOT_W  = 3;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = 16;
   localparam int ACT_W   = 16;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 16;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 40;

   // Reset value of the action mask
   localparam logic [ACT_W-1:0] ACTIONS_RESET = '1;

   typedef enum logic [2:0] {
      V_PENDING = 3'd0,
      V_INVALID = 3'd1,
      V_UNAUTH  = 3'd2,
      V_UNAVAIL = 3'd3,
      V_OVER    = 3'd4,
      V_STALE   = 3'd5,
      V_FUTURE  = 3'd6,
      V_DUP     = 3'd7
   } verdict_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_OWNER_1      = 3'd0,
      CSR_OWNER_2      = 3'd1,
      CSR_OWNER_3      = 3'd2,
      CSR_OWNER_4      = 3'd3,
      CSR_PLAYER_LIMIT = 3'd4,
      CSR_GLOBAL_LIMIT = 3'd5,
      CSR_ALLOWED      = 3'd6
   } csr_index_type;

   // Command item, last-declared field in the lowest bits
   typedef struct packed {
      logic              pad;
      logic              player_accepting;
      logic              match_active;
      logic              link_open;
      logic [WORD_W-1:0] match_tick;
      logic [WORD_W-1:0] second_index;
      logic              is_remote;
      logic [ACT_W-1:0]  action_bits;
      logic [WORD_W-1:0] target_tick;
      logic [WORD_W-1:0] seq_number;
      logic [SLOT_W-1:0] player_slot;
      logic [ID_W-1:0]   claimed_participant;
      logic [ID_W-1:0]   link_participant;
   } req_item_type;

   // Result item, last-declared field in the lowest bits
   typedef struct packed {
      logic [3:0]        pad;
      logic [WORD_W-1:0] effective_tick;
      logic              close_link;
      verdict_type       verdict;
   } rsp_item_type;

endpackage

FILE: rtl/core/player_input_admission_filter_top.sv
// Top level of the player input admission filter: checks, rate windows and result register.
//
// Usage:
//   Commands enter on the req_ stream (req_tvalid/req_tready/req_tdata) and one
//   result per command leaves on the rsp_ stream in the same order. Owners,
//   limits and the action mask are written through csr_we/csr_addr/csr_wdata
//   while the block is idle.
//   A taken command is registered into the check stage, checked there and then
//   moved into the result register (rsp_tvalid high), from which it leaves.
//   Throughput: one command per cycle unless the output stalls or clearing runs;
//   the per-participant window memories are read when the command is taken and
//   written back in the check stage, with a write-first bypass so that
//   back-to-back commands from the same participant see each other.
//   Reset (synchronous, active high) clears the rate windows, sequence records
//   and registers; the action mask resets to all ones. After reset a clearing
//   pass zeroes all PARTICIPANTS (256) entries of the participant memories, and
//   req_tready stays low until it ends.
//   When the receiver stalls, the result register holds its item, the check
//   stage holds behind it and req_tready drops until rsp_tready returns.
module player_input_admission_filter_top
   import piaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // link_participant, claimed_participant, player_slot, seq_number, target_tick,
   // action_bits, is_remote, second_index, match_tick, link_open, match_active,
   // player_accepting, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // verdict, close_link, effective_tick, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_A_W-1:0]    csr_addr,
   input  logic [CSR_D_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [ID_W-1:0]   owner_ff [OWNER_REGS];
   logic [CNT_W-1:0]  pl_limit_ff;
   logic [CNT_W-1:0]  glb_limit_ff;
   logic [ACT_W-1:0]  allowed_ff;

   // Check stage and result register
   req_item_type      s1_ff;
   logic              s1_valid_ff;
   rsp_item_type      rsp_ff;
   rsp_item_type      rsp_in;
   logic              rsp_valid_ff;

   // Per-player and global window state
   logic [WORD_W-1:0] pl_win_ff   [PLAYERS];
   logic [CNT_W-1:0]  pl_used_ff  [PLAYERS];
   logic              pl_valid_ff [PLAYERS];
   logic [WORD_W-1:0] hseq_ff     [PLAYERS];
   logic [WORD_W-1:0] glb_win_ff;
   logic [CNT_W-1:0]  glb_used_ff;
   logic              glb_valid_ff;

   // Per-participant memories; a seen entry is {over valid, seen valid, seen window}
   logic [WORD_W+1:0] seen_mem [PARTICIPANTS];
   logic [WORD_W-1:0] over_mem [PARTICIPANTS];
   logic [WORD_W+1:0] seen_rd_ff;
   logic [WORD_W-1:0] over_rd_ff;
   logic [WORD_W+1:0] seen_wr;

   // Clearing pass after reset
   logic              clr_busy_ff;
   logic [PART_W-1:0] clr_idx_ff;

   req_item_type      req_item;
   logic              req_take;
   logic              s1_go;

   // Check stage decode
   logic [SLOT_W-1:0] slot_m1;
   logic              slot_in_players;
   logic              slot_has_owner;
   logic [ID_W-1:0]   owner;
   logic [PS_W-1:0]   ps;
   logic              in_table;
   logic [PART_W-1:0] pidx;
   logic [PART_W-1:0] ridx;
   logic              seen_v;
   logic              over_v;
   logic              ov_obs;
   logic              pl_fresh;
   logic [CNT_W-1:0]  pl_cur;
   logic              pl_ok;
   logic              glb_fresh;
   logic [CNT_W-1:0]  glb_cur;
   logic              glb_ok;
   logic [WORD_W-1:0] earliest;
   logic [WORD_W-1:0] ahead;
   logic              over_close;
   logic              active_c;
   logic              glb_chk_c;
   logic              accept_c;
   logic              over_hit_c;
   logic              over_set;
   logic              seen_we;
   logic              over_we;

   assign req_item   = req_item_type'(req_tdata);
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_go);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);
   assign ridx       = req_item.link_participant[PART_W-1:0];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OWNER_REGS; i++) owner_ff[i] <= '0;
         pl_limit_ff  <= '0;
         glb_limit_ff <= '0;
         allowed_ff   <= ACTIONS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_OWNER_1:      owner_ff[0]  <= csr_wdata[ID_W-1:0];
            CSR_OWNER_2:      owner_ff[1]  <= csr_wdata[ID_W-1:0];
            CSR_OWNER_3:      owner_ff[2]  <= csr_wdata[ID_W-1:0];
            CSR_OWNER_4:      owner_ff[3]  <= csr_wdata[ID_W-1:0];
            CSR_PLAYER_LIMIT: pl_limit_ff  <= csr_wdata;
            CSR_GLOBAL_LIMIT: glb_limit_ff <= csr_wdata;
            CSR_ALLOWED:      allowed_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sweep the participant memories once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == PART_W'(PARTICIPANTS - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // Decode slot, owner and participant entry
   always_comb begin
      slot_m1         = s1_ff.player_slot - 3'd1;
      slot_in_players = (s1_ff.player_slot != '0) &&
                        ({1'b0, s1_ff.player_slot} <= 4'(PLAYERS));
      slot_has_owner  = slot_in_players &&
                        ({1'b0, s1_ff.player_slot} <= 4'(OWNER_REGS));
      owner           = slot_has_owner ? owner_ff[slot_m1[OWN_W-1:0]] : '0;
      ps              = slot_in_players ? slot_m1[PS_W-1:0] : '0;
      in_table        = ({1'b0, s1_ff.link_participant} < 9'(PARTICIPANTS));
      pidx            = s1_ff.link_participant[PART_W-1:0];
      seen_v          = in_table && seen_rd_ff[WORD_W];
      over_v          = in_table && seen_rd_ff[WORD_W+1];
   end

   // Observe the participant and evaluate both rate windows
   always_comb begin
      if (!seen_v) begin
         ov_obs = 1'b0;
      end else if (seen_rd_ff[WORD_W-1:0] != s1_ff.second_index &&
                   (seen_rd_ff[WORD_W-1:0] + 32'd1) != s1_ff.second_index) begin
         ov_obs = 1'b0;
      end else begin
         ov_obs = over_v;
      end
      pl_fresh   = !pl_valid_ff[ps] || (pl_win_ff[ps] != s1_ff.second_index);
      pl_cur     = pl_fresh ? '0 : pl_used_ff[ps];
      pl_ok      = pl_cur < pl_limit_ff;
      glb_fresh  = !glb_valid_ff || (glb_win_ff != s1_ff.second_index);
      glb_cur    = glb_fresh ? '0 : glb_used_ff;
      glb_ok     = glb_cur < glb_limit_ff;
      earliest   = (s1_ff.match_tick > 32'd2) ? s1_ff.match_tick - 32'd2 : '0;
      ahead      = s1_ff.target_tick - s1_ff.match_tick;
      over_close = s1_ff.is_remote && in_table && ov_obs &&
                   ((over_rd_ff + 32'd1) == s1_ff.second_index);
   end

   // Classify the command; the first failing check decides
   always_comb begin
      rsp_in       = '0;
      rsp_in.verdict = V_PENDING;
      active_c     = 1'b0;
      glb_chk_c    = 1'b0;
      accept_c     = 1'b0;
      over_hit_c   = 1'b0;
      priority if (s1_ff.link_participant == '0 || s1_ff.claimed_participant == '0 ||
                   s1_ff.player_slot == '0) begin
         rsp_in.verdict = V_INVALID;
      end else if (s1_ff.claimed_participant != s1_ff.link_participant ||
                   owner == '0 || owner != s1_ff.link_participant) begin
         rsp_in.verdict    = V_UNAUTH;
         rsp_in.close_link = 1'b1;
      end else if (!s1_ff.link_open) begin
         rsp_in.verdict = V_UNAVAIL;
      end else begin
         active_c = 1'b1;
         priority if (!pl_ok) begin
            rsp_in.verdict    = V_OVER;
            rsp_in.close_link = over_close;
            over_hit_c        = 1'b1;
         end else if (!s1_ff.match_active || s1_ff.seq_number == '0 ||
                      (s1_ff.action_bits & ~allowed_ff) != '0) begin
            rsp_in.verdict = V_INVALID;
         end else if (!s1_ff.player_accepting) begin
            rsp_in.verdict = V_UNAVAIL;
         end else if (s1_ff.target_tick < earliest) begin
            rsp_in.verdict = V_STALE;
         end else if (s1_ff.target_tick > s1_ff.match_tick && ahead > 32'd1) begin
            rsp_in.verdict = V_FUTURE;
         end else if (s1_ff.seq_number <= hseq_ff[ps]) begin
            rsp_in.verdict = V_DUP;
         end else begin
            glb_chk_c = 1'b1;
            if (!glb_ok) begin
               rsp_in.verdict    = V_OVER;
               rsp_in.close_link = over_close;
               over_hit_c        = 1'b1;
            end else begin
               accept_c              = 1'b1;
               rsp_in.effective_tick = (s1_ff.target_tick <= s1_ff.match_tick) ?
                                       s1_ff.match_tick : s1_ff.match_tick + 32'd1;
            end
         end
      end
   end

   assign over_set = over_hit_c && s1_ff.is_remote && in_table;
   assign seen_we  = s1_go && active_c && in_table;
   assign over_we  = s1_go && over_set;
   assign seen_wr  = {over_set || ov_obs, 1'b1, s1_ff.second_index};

   // Advance the check stage and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_ff <= req_item;
      if (s1_go) rsp_ff <= rsp_in;
   end

   // Update per-player and global control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLAYERS; i++) begin
            pl_win_ff[i]   <= '0;
            pl_used_ff[i]  <= '0;
            pl_valid_ff[i] <= 1'b0;
            hseq_ff[i]     <= '0;
         end
         glb_win_ff   <= '0;
         glb_used_ff  <= '0;
         glb_valid_ff <= 1'b0;
      end else if (s1_go) begin
         if (active_c) begin
            pl_valid_ff[ps] <= 1'b1;
            pl_win_ff[ps]   <= s1_ff.second_index;
            pl_used_ff[ps]  <= pl_ok ? pl_cur + 16'd1 : pl_cur;
         end
         if (glb_chk_c) begin
            glb_valid_ff <= 1'b1;
            glb_win_ff   <= s1_ff.second_index;
            glb_used_ff  <= glb_ok ? glb_cur + 16'd1 : glb_cur;
         end
         if (accept_c) hseq_ff[ps] <= s1_ff.seq_number;
      end
   end

   // Participant memories: clear after reset, write in the check stage, read on accept
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         seen_mem[clr_idx_ff] <= '0;
         over_mem[clr_idx_ff] <= '0;
      end else begin
         if (seen_we) seen_mem[pidx] <= seen_wr;
         if (over_we) over_mem[pidx] <= s1_ff.second_index;
      end
      if (req_take) begin
         seen_rd_ff <= (seen_we && pidx == ridx) ? seen_wr : seen_mem[ridx];
         over_rd_ff <= (over_we && pidx == ridx) ? s1_ff.second_index : over_mem[ridx];
      end
   end

`ifndef NO_ASSERTIONS
   // A non-accepted verdict carries no tick
   a_tick_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.verdict != V_PENDING |-> rsp_ff.effective_tick == '0)
      else $error("effective tick on a rejected item");

   // Close only on ownership failure or over limit
   a_close_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.close_link |->
         (rsp_ff.verdict == V_UNAUTH || rsp_ff.verdict == V_OVER))
      else $error("close_link with unexpected verdict");

   // Input stalls only while clearing or behind a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> clr_busy_ff || (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without output backpressure");

   // An accepted command leaves a nonzero global count
   a_global_count: assert property (@(posedge clock) disable iff (reset)
      s1_go && accept_c |=> glb_used_ff != '0 && glb_valid_ff)
      else $error("global window not counted");
`endif

endmodule
